>>> hdl/lsi_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package lsi_pkg;

    // laser selection codes
    localparam logic [1:0] SEL_NONE = 2'd0;
    localparam logic [1:0] SEL_MAIN = 2'd1;
    localparam logic [1:0] SEL_VIS  = 2'd2;

    // debounce lockout length after reset
    localparam logic [7:0] DEBOUNCE_RESET = 8'd10;

    localparam int IN_DATA_W  = 8;
    localparam int OUT_DATA_W = 16;

    // input request, last field in the lowest bit
    typedef struct packed {
        logic       clear_request;
        logic       override_closed;
        logic       override_open;
        logic [1:0] laser_select;
        logic       lid_pin;
        logic       stop_pin;
    } in_item_t;

    // result, last field in the lowest bit
    typedef struct packed {
        logic debouncing;
        logic lid_up;
        logic stop_down;
        logic clear_refused;
        logic lid_closed_fault;
        logic lid_open_fault;
        logic estop_fault;
        logic vis_ok;
        logic main_ok;
        logic move_ok;
    } out_item_t;

endpackage

`default_nettype wire

>>> hdl/lsi_eval.sv
`timescale 1ns / 1ps
`default_nettype none

module lsi_eval
    import lsi_pkg::*;
(
    input  wire             clk,
    input  wire             rst_n,
    input  wire             fire,
    input  wire in_item_t   item,
    input  wire [7:0]       debounce_ticks,
    output out_item_t       result
);

    logic       primed_reg;
    logic [1:0] switch_reg;
    logic [1:0] switch_next;
    logic       estop_reg;
    logic       estop_next;
    logic [7:0] lockout_reg;
    logic [7:0] lockout_next;
    logic [1:0] pins;
    logic       stop;
    logic       lid;

    // switch sampling and debounce lockout
    always_comb
    begin
        pins         = {item.lid_pin, item.stop_pin};
        switch_next  = switch_reg;
        lockout_next = lockout_reg;
        if (!primed_reg)
        begin
            switch_next = pins;
        end
        else if (lockout_reg != 8'd0)
        begin
            lockout_next = lockout_reg - 8'd1;
            if (lockout_next == 8'd0)
            begin
                switch_next = pins;
            end
        end
        else if (pins != switch_reg)
        begin
            switch_next  = pins;
            lockout_next = debounce_ticks;
        end
    end

    assign stop = switch_next[0];
    assign lid  = switch_next[1];

    // sticky e-stop fault, clear judged against the new stop state
    always_comb
    begin
        estop_next = estop_reg;
        if (item.clear_request && !stop)
        begin
            estop_next = 1'b0;
        end
        if (stop)
        begin
            estop_next = 1'b1;
        end
    end

    // permits and faults
    always_comb
    begin
        result.move_ok          = !estop_next;
        result.main_ok          = !estop_next && (!lid || item.override_open);
        result.vis_ok           = !estop_next && (lid || item.override_closed);
        result.estop_fault      = estop_next;
        result.lid_open_fault   = (item.laser_select == SEL_MAIN) && lid
                                  && !item.override_open;
        result.lid_closed_fault = (item.laser_select == SEL_VIS) && !lid
                                  && !item.override_closed;
        result.clear_refused    = item.clear_request && stop;
        result.stop_down        = stop;
        result.lid_up           = lid;
        result.debouncing       = (lockout_next != 8'd0);
    end

    // state update once per request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            primed_reg  <= 1'b0;
            switch_reg  <= 2'b00;
            estop_reg   <= 1'b0;
            lockout_reg <= 8'd0;
        end
        else if (fire)
        begin
            primed_reg  <= 1'b1;
            switch_reg  <= switch_next;
            estop_reg   <= estop_next;
            lockout_reg <= lockout_next;
        end
    end

endmodule

`default_nettype wire

>>> hdl/laser_safety_interlock.sv
// laser safety interlock, one request per timer tick
// path: the request is held in the input register, then its result in the result register
// throughput: one request per cycle unless a held result waits on m_tready, set by the input and result registers
// reset: asynchronous, active low; clears faults, lockout and both stages,
// the first request after reset loads the pins with no lockout
`timescale 1ns / 1ps
`default_nettype none

module laser_safety_interlock
    import lsi_pkg::*;
(
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  cfg_wr_en,
    input  wire [7:0]            cfg_wr_data,
    input  wire                  s_tvalid,
    output logic                 s_tready,
    // stop_pin, lid_pin, laser_select[1:0], override_open, override_closed,
    // clear_request, pad
    input  wire [IN_DATA_W-1:0]  s_tdata,
    output logic                 m_tvalid,
    input  wire                  m_tready,
    // move_ok, main_ok, vis_ok, estop_fault, lid_open_fault, lid_closed_fault,
    // clear_refused, stop_down, lid_up, debouncing, pad
    output logic [OUT_DATA_W-1:0] m_tdata
);

    localparam int IN_W  = $bits(in_item_t);
    localparam int OUT_W = $bits(out_item_t);

    logic      [7:0] debounce_reg;
    logic            in_valid_reg;
    logic            in_valid_next;
    in_item_t        in_item_reg;
    logic            out_valid_reg;
    logic            out_valid_next;
    out_item_t       out_item_reg;
    out_item_t       result;
    logic            advance;
    logic            move;
    logic            in_accept;

    // debounce length register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_reg <= DEBOUNCE_RESET;
        end
        else if (cfg_wr_en)
        begin
            debounce_reg <= cfg_wr_data;
        end
    end

    // stage handshake
    assign advance   = !out_valid_reg || m_tready;
    assign move      = in_valid_reg && advance;
    assign s_tready  = !in_valid_reg || advance;
    assign in_accept = s_tvalid && s_tready;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_accept)
        begin
            in_valid_next = 1'b1;
        end
        else if (move)
        begin
            in_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (move)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            in_item_reg <= in_item_t'(s_tdata[IN_W-1:0]);
        end
        if (move)
        begin
            out_item_reg <= result;
        end
    end

    // interlock evaluation
    lsi_eval u_eval (
        .clk            (clk),
        .rst_n          (rst_n),
        .fire           (move),
        .item           (in_item_reg),
        .debounce_ticks (debounce_reg),
        .result         (result)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OUT_DATA_W-OUT_W){1'b0}}, out_item_reg};

    // a stored stop switch always holds the e-stop fault
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && out_item_reg.stop_down |-> out_item_reg.estop_fault)
        else $error("stop down without e-stop fault");

    // an accepted request always lands in the input stage
    assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> in_valid_reg)
        else $error("accepted request lost");

    // a refused clear only happens with the stop switch down
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && out_item_reg.clear_refused |-> out_item_reg.stop_down)
        else $error("clear refused with stop switch up");

    // input stage stalls only when the result stage is held
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (in_valid_reg && out_valid_reg && !m_tready))
        else $error("input stalled without backpressure");

endmodule

`default_nettype wire
